/* rtl/fcd_pkg.sv */
// Shared types and constants for the framed command dimmer.
// No dependencies; used by fcd_core and framed_command_dimmer_top.
`timescale 1ns / 1ps
`default_nettype none

package fcd_pkg;

  localparam int unsigned MAX_PAYLOAD = 16;
  localparam int unsigned LEN_W       = $clog2(MAX_PAYLOAD);

  localparam logic [7:0] START_BYTE = 8'h3C;  // '<'
  localparam logic [7:0] END_BYTE   = 8'h3E;  // '>'
  localparam logic [7:0] MAX_LEN    = 8'(MAX_PAYLOAD);

  localparam logic signed [3:0] FADE_DELTA = 4'sd1;
  localparam logic signed [3:0] FADE_RESET     = 4'sd5;
  localparam logic [7:0]        LEVEL_FULL     = 8'd255;
  localparam logic [7:0]        LEVEL_MIN      = 8'd1;

  // frame commands
  localparam logic [7:0] CMD_NOP   = 8'd0;
  localparam logic [7:0] CMD_LEVEL = 8'd1;
  localparam logic [7:0] CMD_MODE  = 8'd2;

  // sleep modes
  localparam logic [7:0] MODE_OFF  = 8'd0;
  localparam logic [7:0] MODE_FULL = 8'd1;
  localparam logic [7:0] MODE_FADE = 8'd2;
  localparam logic [7:0] MODE_MIN  = 8'd3;

  // item kinds
  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_SERVICE = 1'b1;

  typedef enum logic [2:0] {
    PH_WAIT  = 3'd0,
    PH_LEN   = 3'd1,
    PH_CMD   = 3'd2,
    PH_DATA  = 3'd3,
    PH_CHECK = 3'd4
  } phase_e;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
    logic       switch_on;
    logic       fade_due;
  } item_t;

  typedef struct packed {
    logic [7:0]  pwm_level;
    logic        frame_done;
    logic        frame_bad;
    logic [15:0] error_total;
    logic [7:0]  mode_now;
  } result_t;

endpackage

`default_nettype wire

/* rtl/fcd_core.sv */
// Frame parser, command execution and sleep-mode engine of the dimmer.
// Holds all block state; depends on fcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcd_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,   // process item_i this cycle
  input  wire fcd_pkg::item_t  item_i,
  output fcd_pkg::result_t     result_o  // result of item_i (next state view)
);

  fcd_pkg::phase_e                 phase_q, phase_d;
  logic [fcd_pkg::LEN_W-1:0]       len_q, len_d;
  logic [fcd_pkg::LEN_W-1:0]       seen_q, seen_d;
  logic [fcd_pkg::LEN_W-1:0]       seen_inc;
  logic [7:0]                      fcmd_q, fcmd_d;
  logic [7:0]                      first_q, first_d;
  logic [7:0]                      level_q, level_d;
  logic [7:0]                      mode_q, mode_d;
  logic signed [3:0]               step_q, step_d;
  logic signed [3:0]               step_fade;
  logic signed [9:0]               level_sum;
  logic [15:0]                     errs_q, errs_d;
  logic                            done, bad;

  assign seen_inc = seen_q + 1'b1;

  // fade: direction flips at the ends, then one saturating step per tick
  always_comb begin
    step_fade = step_q;
    if (level_q <= fcd_pkg::LEVEL_MIN) begin
      step_fade = fcd_pkg::FADE_DELTA;
    end
    if (level_q == fcd_pkg::LEVEL_FULL) begin
      step_fade = -fcd_pkg::FADE_DELTA;
    end
    level_sum = $signed({2'b00, level_q}) + $signed({{6{step_fade[3]}}, step_fade});
  end

  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    seen_d  = seen_q;
    fcmd_d  = fcmd_q;
    first_d = first_q;
    level_d = level_q;
    mode_d  = mode_q;
    step_d  = step_q;
    errs_d  = errs_q;
    done    = 1'b0;
    bad     = 1'b0;

    if (item_i.cmd == fcd_pkg::KIND_SERVICE) begin
      if (!item_i.switch_on) begin
        unique case (mode_q)
          fcd_pkg::MODE_OFF:  level_d = 8'd0;
          fcd_pkg::MODE_FULL: level_d = fcd_pkg::LEVEL_FULL;
          fcd_pkg::MODE_MIN:  level_d = fcd_pkg::LEVEL_MIN;
          fcd_pkg::MODE_FADE: begin
            step_d = step_fade;
            if (item_i.fade_due) begin
              if (level_sum < 10'sd0) begin
                level_d = 8'd0;
              end else if (level_sum > 10'sd255) begin
                level_d = fcd_pkg::LEVEL_FULL;
              end else begin
                level_d = level_sum[7:0];
              end
            end
          end
          default: ;  // unknown mode leaves the level alone
        endcase
      end
    end else begin
      unique case (phase_q)
        fcd_pkg::PH_LEN: begin
          len_d   = item_i.rx_byte[fcd_pkg::LEN_W-1:0];
          phase_d = (item_i.rx_byte >= fcd_pkg::MAX_LEN) ? fcd_pkg::PH_WAIT
                                                          : fcd_pkg::PH_CMD;
        end
        fcd_pkg::PH_CMD: begin
          fcmd_d  = item_i.rx_byte;
          phase_d = (len_q != '0) ? fcd_pkg::PH_DATA : fcd_pkg::PH_CHECK;
        end
        fcd_pkg::PH_DATA: begin
          if (seen_q == '0) begin
            first_d = item_i.rx_byte;
          end
          seen_d = seen_inc;
          if (seen_inc == len_q) begin
            phase_d = fcd_pkg::PH_CHECK;
          end
        end
        fcd_pkg::PH_CHECK: begin
          phase_d = fcd_pkg::PH_WAIT;
          if (item_i.rx_byte == fcd_pkg::END_BYTE) begin
            done = 1'b1;
            if (fcmd_q == fcd_pkg::CMD_LEVEL) begin
              if (item_i.switch_on) begin
                level_d = first_q;
              end
            end else if (fcmd_q == fcd_pkg::CMD_MODE) begin
              mode_d = first_q;
            end
          end else begin
            errs_d = errs_q + 16'd1;
            bad    = 1'b1;
          end
        end
        default: begin  // waiting for start, and any stray code
          if (item_i.rx_byte == fcd_pkg::START_BYTE) begin
            phase_d = fcd_pkg::PH_LEN;
            seen_d  = '0;
          end else begin
            phase_d = fcd_pkg::PH_WAIT;
          end
        end
      endcase
    end
  end

  always_comb begin
    result_o.pwm_level   = level_d;
    result_o.frame_done  = done;
    result_o.frame_bad   = bad;
    result_o.error_total = errs_d;
    result_o.mode_now    = mode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= fcd_pkg::PH_WAIT;
      len_q   <= '0;
      seen_q  <= '0;
      fcmd_q  <= '0;
      first_q <= '0;
      level_q <= '0;
      mode_q  <= '0;
      step_q  <= fcd_pkg::FADE_RESET;
      errs_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      seen_q  <= seen_d;
      fcmd_q  <= fcmd_d;
      first_q <= first_d;
      level_q <= level_d;
      mode_q  <= mode_d;
      step_q  <= step_d;
      errs_q  <= errs_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/framed_command_dimmer_top.sv */
// Top level of the framed command dimmer: input register, core, result register.
// Depends on fcd_pkg and fcd_core.
`timescale 1ns / 1ps
`default_nettype none

// The dimmer takes one item per transfer: either a received serial byte
// (cmd_i = 0) or an output service pass (cmd_i = 1), and returns exactly one
// result per item, in order. Bytes are deframed as '<', length, command,
// payload, '>'; a good frame sets the lamp level (command 1, switch on only)
// or the sleep mode (command 2), a wrong end byte bumps a 16-bit wrapping
// error count. A service pass with the switch off applies the sleep mode
// (off, full, triangle fade, minimum). Throughput is one item per clock while
// the result register is not stalled: each item is captured in the input
// register, and as it leaves it the core updates its state and loads the
// result register. Both sides use valid/stall; the input stalls only while
// both the input register and the result register are held.

module framed_command_dimmer_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        cmd_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        switch_on_i,
  input  wire logic        fade_due_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       pwm_level_o,
  output logic             frame_done_o,
  output logic             frame_bad_o,
  output logic [15:0]      error_total_o,
  output logic [7:0]       mode_now_o
);

  logic              in_valid_q;
  fcd_pkg::item_t    item_q;
  logic              out_valid_q;
  fcd_pkg::result_t  res_q;
  fcd_pkg::result_t  res_d;
  logic              out_free;   // result register can take a new value
  logic              step;       // core consumes the input register
  logic              in_take;    // input transfer

  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  fcd_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item_q),
    .result_o (res_d)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.cmd       <= cmd_i;
      item_q.rx_byte   <= rx_byte_i;
      item_q.switch_on <= switch_on_i;
      item_q.fade_due  <= fade_due_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pwm_level_o   = res_q.pwm_level;
  assign frame_done_o  = res_q.frame_done;
  assign frame_bad_o   = res_q.frame_bad;
  assign error_total_o = res_q.error_total;
  assign mode_now_o    = res_q.mode_now;

endmodule

`default_nettype wire
